// ----- design/vfad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vfad_pkg;

  localparam int VEL_WIDTH_DEF = 40;
  localparam int ACCEL_W       = 16;
  localparam int TS_W          = 32;
  localparam int OUT_W         = 40;
  localparam int MUL_B_W       = 16;

  localparam int DEADBAND_W = 16;
  localparam int FRICTION_W = 16;
  localparam int STOP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 16'd25;
  localparam logic [FRICTION_W-1:0] FRICTION_RST = 16'd55706;
  localparam logic [STOP_W-1:0]     STOP_RST     = 24'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND = 2'd0,
    REG_FRICTION = 2'd1,
    REG_STOP     = 2'd2
  } vfad_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_WR_X,
    ST_MUL_Y,
    ST_WR_Y,
    ST_SQ,
    ST_SQ_DRAIN,
    ST_RT_INIT,
    ST_RT,
    ST_DONE
  } vfad_state_t;

  typedef struct packed {
    logic first;
    logic start;
    logic mul_x;
    logic mul_y;
    logic wr_x;
    logic wr_y;
    logic sq_step;
    logic rt_init;
    logic rt_step;
    logic load_out;
  } vfad_cmd_t;

  typedef struct packed {
    logic sq_done;
    logic rt_last;
  } vfad_stat_t;

endpackage

`default_nettype wire

// ----- design/velocity_from_accel_deadband.sv -----
// Two-axis velocity integrator with deadband decay and stop threshold.
// Input channel (in_valid/in_ready) takes one word: accel_x, accel_y and
// timestamp_ms. The first word after reset only records its timestamp and
// gives no result; every later word gives exactly one result word on the
// output channel (out_valid/out_ready): speed, velocity_x, velocity_y.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 deadband, 1 friction, 2 stop threshold, others ignored.
// Write it only while the block is idle.
// One word at a time: a new word is accepted only when the block is idle
// again after the last one. The time a word takes is set by the square
// root unit, one result bit a cycle, and by the 16-bit wide shared
// multiplier that forms the sum of squares one digit a cycle.
// Reset restores the register defaults, clears both velocities and forgets
// the stored timestamp. The result sits in an output register; while the
// receiver stalls, the next word is still accepted and worked on, and the
// block waits only when that next result is ready and the register is full.
`timescale 1ns / 1ps
`default_nettype none

module velocity_from_accel_deadband #(
  parameter int VEL_WIDTH = vfad_pkg::VEL_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [vfad_pkg::ACCEL_W-1:0]    accel_x,
  input  logic signed [vfad_pkg::ACCEL_W-1:0]    accel_y,
  input  logic        [vfad_pkg::TS_W-1:0]       timestamp_ms,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [vfad_pkg::OUT_W-1:0]      speed,
  output logic signed [vfad_pkg::OUT_W-1:0]      velocity_x,
  output logic signed [vfad_pkg::OUT_W-1:0]      velocity_y,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [vfad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [vfad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vfad_pkg::*;

  vfad_cmd_t  cmd;
  vfad_stat_t stat;

  assign cfg_ready = 1'b1;

  vfad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vfad_dp #(
    .VEL_WIDTH (VEL_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .timestamp_ms (timestamp_ms),
    .cmd          (cmd),
    .stat         (stat),
    .speed        (speed),
    .velocity_x   (velocity_x),
    .velocity_y   (velocity_y)
  );

endmodule

`default_nettype wire

// ----- design/vfad_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vfad_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  vfad_pkg::vfad_stat_t stat,
  output vfad_pkg::vfad_cmd_t  cmd
);
  import vfad_pkg::*;

  vfad_state_t state;
  vfad_state_t state_next;
  logic        have_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      have_sample <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.first) begin
        have_sample <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!have_sample) begin
            cmd.first = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_MUL_X;
          end
        end
      end
      ST_MUL_X: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_WR_X;
      end
      ST_WR_X: begin
        cmd.wr_x   = 1'b1;
        state_next = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_y  = 1'b1;
        state_next = ST_WR_Y;
      end
      ST_WR_Y: begin
        cmd.wr_y   = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        if (stat.sq_done) begin
          state_next = ST_SQ_DRAIN;
        end
      end
      ST_SQ_DRAIN: begin
        state_next = ST_RT_INIT;
      end
      ST_RT_INIT: begin
        cmd.rt_init = 1'b1;
        state_next  = ST_RT;
      end
      ST_RT: begin
        cmd.rt_step = 1'b1;
        if (stat.rt_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/vfad_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vfad_dp #(
  parameter int VEL_WIDTH = vfad_pkg::VEL_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic        [vfad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [vfad_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [vfad_pkg::ACCEL_W-1:0]    accel_x,
  input  logic signed [vfad_pkg::ACCEL_W-1:0]    accel_y,
  input  logic        [vfad_pkg::TS_W-1:0]       timestamp_ms,
  input  vfad_pkg::vfad_cmd_t                    cmd,
  output vfad_pkg::vfad_stat_t                   stat,
  output logic        [vfad_pkg::OUT_W-1:0]      speed,
  output logic signed [vfad_pkg::OUT_W-1:0]      velocity_x,
  output logic signed [vfad_pkg::OUT_W-1:0]      velocity_y
);
  import vfad_pkg::*;

  localparam int VW    = VEL_WIDTH;
  localparam int PW    = VW + MUL_B_W;
  localparam int SUMW  = VW + 2;
  localparam int NCH   = (VW + MUL_B_W - 1) / MUL_B_W;
  localparam int CIW   = $clog2(NCH);
  localparam int SW    = 2 * VW;
  localparam int RW    = VW + 3;
  localparam int CNT_W = $clog2(VW);
  localparam int XW    = VW + OUT_W;

  // configuration
  logic [DEADBAND_W-1:0] deadband;
  logic [FRICTION_W-1:0] friction;
  logic [STOP_W-1:0]     stop_thr;

  // sample registers
  logic [TS_W-1:0]          last_time;
  logic signed [ACCEL_W-1:0] ax;
  logic signed [ACCEL_W-1:0] ay;
  logic [MUL_B_W-1:0]       dt;
  logic [TS_W-1:0]          dt_raw;
  logic [MUL_B_W-1:0]       dt_clamped;

  // velocity state
  logic [VW-1:0] vel_x;
  logic [VW-1:0] vel_y;
  logic [VW-1:0] mag_x;
  logic [VW-1:0] mag_y;
  logic [ACCEL_W-1:0] am_x;
  logic [ACCEL_W-1:0] am_y;
  logic dead_x;
  logic dead_y;
  logic [VW-1:0] vel_upd;

  // shared multiplier
  logic [VW-1:0]      mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PW-1:0]      prod;
  logic [VW-1:0]      sq_src;
  logic [MUL_B_W-1:0] sq_chunk;

  // sum of squares
  logic [CIW-1:0] sq_idx;
  logic           sq_axis;
  logic [CIW-1:0] prod_sh;
  logic           acc_pend;
  logic [SW-1:0]  acc;

  // square root
  logic [SW-1:0]    rt_s;
  logic [RW-1:0]    rem;
  logic [VW-1:0]    root;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    rem2;
  logic [RW-1:0]    trial;
  logic             ge;

  // result
  logic          below;
  logic [XW-1:0] spd_wide;
  logic [XW-1:0] vx_wide;
  logic [XW-1:0] vy_wide;
  logic [OUT_W-1:0] spd_sat;

  function automatic logic [VW-1:0] axis_next(
    input logic [VW-1:0] v,
    input logic          a_neg,
    input logic          dead,
    input logic [PW-1:0] p
  );
    logic [VW-1:0]   scaled;
    logic [SUMW-1:0] term;
    logic [SUMW-1:0] sum;
    logic [VW-1:0]   res;
    scaled = p[VW+MUL_B_W-1:MUL_B_W];
    term   = p[SUMW-1:0];
    if (a_neg) begin
      term = -term;
    end
    sum = {{2{v[VW-1]}}, v} + term;
    if (dead) begin
      res = v[VW-1] ? -scaled : scaled;
    end else if (sum[SUMW-1:VW-1] == '0 || sum[SUMW-1:VW-1] == '1) begin
      res = sum[VW-1:0];
    end else if (sum[SUMW-1]) begin
      res = {1'b1, {(VW-1){1'b0}}};
    end else begin
      res = {1'b0, {(VW-1){1'b1}}};
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DEADBAND_RST;
      friction <= FRICTION_RST;
      stop_thr <= STOP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEADBAND: deadband <= cfg_data[DEADBAND_W-1:0];
        REG_FRICTION: friction <= cfg_data[FRICTION_W-1:0];
        REG_STOP:     stop_thr <= cfg_data[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  assign dt_raw     = timestamp_ms - last_time;
  assign dt_clamped = (|dt_raw[TS_W-1:MUL_B_W]) ? '1 : dt_raw[MUL_B_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.first || cmd.start) begin
      last_time <= timestamp_ms;
    end
    if (cmd.start) begin
      ax <= accel_x;
      ay <= accel_y;
      dt <= dt_clamped;
    end
  end

  assign mag_x  = vel_x[VW-1] ? -vel_x : vel_x;
  assign mag_y  = vel_y[VW-1] ? -vel_y : vel_y;
  assign am_x   = ax[ACCEL_W-1] ? ACCEL_W'(-ax) : ACCEL_W'(ax);
  assign am_y   = ay[ACCEL_W-1] ? ACCEL_W'(-ay) : ACCEL_W'(ay);
  assign dead_x = am_x < deadband;
  assign dead_y = am_y < deadband;

  assign sq_src   = sq_axis ? mag_y : mag_x;
  assign sq_chunk = MUL_B_W'(sq_src >> (MUL_B_W * sq_idx));

  always_comb begin
    if (cmd.mul_x) begin
      mul_a = dead_x ? mag_x : VW'(am_x);
      mul_b = dead_x ? friction : dt;
    end else if (cmd.mul_y) begin
      mul_a = dead_y ? mag_y : VW'(am_y);
      mul_b = dead_y ? friction : dt;
    end else begin
      mul_a = sq_src;
      mul_b = sq_chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y || cmd.sq_step) begin
      prod <= PW'(mul_a) * PW'(mul_b);
    end
    if (cmd.sq_step) begin
      prod_sh <= sq_idx;
    end
  end

  assign vel_upd = cmd.wr_y ? axis_next(vel_y, ay[ACCEL_W-1], dead_y, prod)
                            : axis_next(vel_x, ax[ACCEL_W-1], dead_x, prod);

  assign spd_wide = XW'(root);
  assign spd_sat  = (|spd_wide[XW-1:OUT_W]) ? '1 : spd_wide[OUT_W-1:0];
  assign vx_wide  = {{OUT_W{vel_x[VW-1]}}, vel_x};
  assign vy_wide  = {{OUT_W{vel_y[VW-1]}}, vel_y};
  assign below    = root < VW'(stop_thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_x <= '0;
      vel_y <= '0;
    end else if (cmd.wr_x) begin
      vel_x <= vel_upd;
    end else if (cmd.wr_y) begin
      vel_y <= vel_upd;
    end else if (cmd.load_out && below) begin
      vel_x <= '0;
      vel_y <= '0;
    end
  end

  // sum of squares, one 16-bit digit of the multiplier a step
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
    end else begin
      acc_pend <= cmd.sq_step;
    end
    if (cmd.start) begin
      sq_idx  <= '0;
      sq_axis <= 1'b0;
      acc     <= '0;
    end else begin
      if (cmd.sq_step) begin
        if (sq_idx == CIW'(NCH - 1)) begin
          sq_idx  <= '0;
          sq_axis <= 1'b1;
        end else begin
          sq_idx <= sq_idx + 1'b1;
        end
      end
      if (acc_pend) begin
        acc <= acc + (SW'(prod) << (MUL_B_W * prod_sh));
      end
    end
  end

  assign stat.sq_done = sq_axis && (sq_idx == CIW'(NCH - 1));

  // digit-by-digit square root, two radicand bits a step
  assign rem2  = {rem[RW-3:0], rt_s[SW-1 -: 2]};
  assign trial = RW'({root, 2'b01});
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (cmd.rt_init) begin
      rt_s <= acc;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (cmd.rt_step) begin
      rt_s <= rt_s << 2;
      rem  <= ge ? rem2 - trial : rem2;
      root <= {root[VW-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
  end

  assign stat.rt_last = cnt == CNT_W'(VW - 1);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (below) begin
        speed      <= '0;
        velocity_x <= '0;
        velocity_y <= '0;
      end else begin
        speed      <= spd_sat;
        velocity_x <= vx_wide[OUT_W-1:0];
        velocity_y <= vy_wide[OUT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/vfad_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vfad_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic        [vfad_pkg::OUT_W-1:0] speed,
  input logic signed [vfad_pkg::OUT_W-1:0] velocity_x,
  input logic signed [vfad_pkg::OUT_W-1:0] velocity_y
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(speed)
      && $stable(velocity_x) && $stable(velocity_y))
    else $error("result word changed while stalled");

  // zero speed only with both velocities at rest
  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && speed == '0 |-> velocity_x == '0 && velocity_y == '0)
    else $error("zero speed with moving velocity");

  // a new result only comes out of a busy period
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind velocity_from_accel_deadband vfad_checker u_vfad_checker (.*);

`default_nettype wire
